// ===== src/jsu_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// jsu_pkg
// Shared types and constants for the JSON string unescaper.
// ============================================================================
package jsu_pkg;

    // Width of the decoded byte limit and of the decoded byte counter
    localparam int LIMIT_WIDTH = 16;
    localparam int COUNT_WIDTH = LIMIT_WIDTH + 1;

    // Result queue between the parser and the output stage
    localparam int QDEPTH     = 8;
    localparam int QPTR_WIDTH = $clog2(QDEPTH);
    localparam int QCNT_WIDTH = $clog2(QDEPTH + 1);

    // Decoded byte limit after reset
    localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = LIMIT_WIDTH'(4096);

    // Result kinds
    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_DONE = 2'd1,
        KIND_ERR  = 2'd2
    } kind_t;

    // Error codes
    typedef enum logic [2:0] {
        ERR_NONE    = 3'd0,
        ERR_TRUNC   = 3'd1,
        ERR_QUOTE   = 3'd2,
        ERR_INVALID = 3'd3,
        ERR_LIMIT   = 3'd4
    } err_t;

    // Parser phases
    typedef enum logic [3:0] {
        ST_IDLE    = 4'd0,
        ST_BODY    = 4'd1,
        ST_ESC     = 4'd2,
        ST_HEX1    = 4'd3,
        ST_WANT_BS = 4'd4,
        ST_WANT_U  = 4'd5,
        ST_HEX2    = 4'd6
    } state_t;

    // One queue entry: all results caused by one input beat
    typedef struct packed {
        logic [3:0][7:0] bytes;     // data bytes, bytes[0] goes out first
        logic [1:0]      last_idx;  // index of the final result
        kind_t           kind;
        err_t            err;
    } entry_t;

endpackage

// ===== src/jsu_front.sv =====
`timescale 1ns / 1ps
// ============================================================================
// jsu_front
// Parser: takes one raw byte per beat, tracks escapes and \u sequences,
// and pushes the results of each byte into the result queue as one entry.
// ============================================================================
module jsu_front
    import jsu_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_accept,
    input  logic [7:0]             in_byte,
    input  logic                   in_end,
    input  logic [LIMIT_WIDTH-1:0] limit,
    output logic                   push,
    output entry_t                 push_entry
);

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_B = 8'h62;
    localparam logic [7:0] CH_F = 8'h66;
    localparam logic [7:0] CH_N = 8'h6E;
    localparam logic [7:0] CH_R = 8'h72;
    localparam logic [7:0] CH_T = 8'h74;
    localparam logic [7:0] CH_U = 8'h75;

    state_t                 state_reg, state_next;
    logic [1:0]             hex_cnt_reg, hex_cnt_next;
    logic [15:0]            unit1_reg, unit1_next;
    logic [15:0]            unit2_reg, unit2_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;

    logic [3:0]  nib;
    logic        is_hex;
    logic [15:0] unit1_shift;
    logic [15:0] unit2_shift;
    logic [20:0] pair_cp;

    logic            fin;
    kind_t           fin_kind;
    err_t            fin_err;
    logic            em_raw;
    logic [7:0]      raw_byte;
    logic            em_cp;
    logic [20:0]     cp;
    logic            emit;
    logic [3:0][7:0] em_bytes;
    logic [1:0]      em_last;
    logic [2:0]      em_n;
    logic [COUNT_WIDTH-1:0] count_sum;

    // Hex digit decode
    always_comb
    begin
        is_hex = 1'b1;
        nib    = 4'd0;
        if (in_byte >= 8'h30 && in_byte <= 8'h39)
        begin
            nib = 4'(in_byte - 8'h30);
        end
        else if (in_byte >= 8'h61 && in_byte <= 8'h66)
        begin
            nib = 4'(in_byte - 8'h57);
        end
        else if (in_byte >= 8'h41 && in_byte <= 8'h46)
        begin
            nib = 4'(in_byte - 8'h37);
        end
        else
        begin
            is_hex = 1'b0;
        end
    end

    assign unit1_shift = {unit1_reg[11:0], nib};
    assign unit2_shift = {unit2_reg[11:0], nib};
    // Surrogate pair: 0x10000 + low ten bits of first unit as high half + low ten bits of second
    assign pair_cp = 21'h10000 + {1'b0, unit1_reg[9:0], unit2_shift[9:0]};

    // Next state and result entry
    always_comb
    begin
        state_next   = state_reg;
        hex_cnt_next = hex_cnt_reg;
        unit1_next   = unit1_reg;
        unit2_next   = unit2_reg;
        count_next   = count_reg;
        fin          = 1'b0;
        fin_kind     = KIND_ERR;
        fin_err      = ERR_NONE;
        em_raw       = 1'b0;
        raw_byte     = in_byte;
        em_cp        = 1'b0;
        cp           = 21'd0;
        em_bytes     = '0;
        em_last      = 2'd0;
        emit         = 1'b0;
        push         = 1'b0;
        push_entry   = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_end)
                begin
                    fin = 1'b1; fin_err = ERR_TRUNC;
                end
                else if (in_byte != CH_QUOTE)
                begin
                    fin = 1'b1; fin_err = ERR_QUOTE;
                end
                else
                begin
                    state_next = ST_BODY;
                    count_next = '0;
                end
            end
            ST_BODY:
            begin
                if (in_end)
                begin
                    fin = 1'b1; fin_err = ERR_TRUNC;
                end
                else if (in_byte == CH_QUOTE)
                begin
                    fin = 1'b1; fin_kind = KIND_DONE;
                end
                else if (in_byte < CH_SPACE)
                begin
                    fin = 1'b1; fin_err = ERR_INVALID;
                end
                else if (in_byte == CH_BSLASH)
                begin
                    state_next = ST_ESC;
                end
                else
                begin
                    em_raw = 1'b1;
                end
            end
            ST_ESC:
            begin
                if (in_end)
                begin
                    fin = 1'b1; fin_err = ERR_TRUNC;
                end
                else
                begin
                    case (in_byte)
                        CH_QUOTE, CH_BSLASH, CH_SLASH: em_raw = 1'b1;
                        CH_B: begin em_raw = 1'b1; raw_byte = 8'h08; end
                        CH_F: begin em_raw = 1'b1; raw_byte = 8'h0C; end
                        CH_N: begin em_raw = 1'b1; raw_byte = 8'h0A; end
                        CH_R: begin em_raw = 1'b1; raw_byte = 8'h0D; end
                        CH_T: begin em_raw = 1'b1; raw_byte = 8'h09; end
                        CH_U:
                        begin
                            state_next   = ST_HEX1;
                            hex_cnt_next = 2'd0;
                            unit1_next   = 16'd0;
                        end
                        default:
                        begin
                            fin = 1'b1; fin_err = ERR_INVALID;
                        end
                    endcase
                end
            end
            ST_HEX1:
            begin
                if (in_end)
                begin
                    fin = 1'b1; fin_err = ERR_TRUNC;
                end
                else if (!is_hex)
                begin
                    fin = 1'b1; fin_err = ERR_INVALID;
                end
                else
                begin
                    unit1_next = unit1_shift;
                    if (hex_cnt_reg != 2'd3)
                    begin
                        hex_cnt_next = hex_cnt_reg + 2'd1;
                    end
                    else
                    begin
                        hex_cnt_next = 2'd0;
                        if (unit1_shift >= 16'hD800 && unit1_shift <= 16'hDBFF)
                        begin
                            state_next = ST_WANT_BS;
                        end
                        else
                        begin
                            em_cp = 1'b1;
                            cp    = {5'd0, unit1_shift};
                        end
                    end
                end
            end
            ST_WANT_BS:
            begin
                if (in_end || in_byte != CH_BSLASH)
                begin
                    fin = 1'b1; fin_err = ERR_INVALID;
                end
                else
                begin
                    state_next = ST_WANT_U;
                end
            end
            ST_WANT_U:
            begin
                if (in_end || in_byte != CH_U)
                begin
                    fin = 1'b1; fin_err = ERR_INVALID;
                end
                else
                begin
                    state_next   = ST_HEX2;
                    hex_cnt_next = 2'd0;
                    unit2_next   = 16'd0;
                end
            end
            ST_HEX2:
            begin
                if (in_end || !is_hex)
                begin
                    fin = 1'b1; fin_err = ERR_INVALID;
                end
                else
                begin
                    unit2_next = unit2_shift;
                    if (hex_cnt_reg != 2'd3)
                    begin
                        hex_cnt_next = hex_cnt_reg + 2'd1;
                    end
                    else
                    begin
                        hex_cnt_next = 2'd0;
                        if (unit2_shift < 16'hDC00 || unit2_shift > 16'hDFFF)
                        begin
                            fin = 1'b1; fin_err = ERR_INVALID;
                        end
                        else
                        begin
                            em_cp = 1'b1;
                            cp    = pair_cp;
                        end
                    end
                end
            end
            default:
            begin
                state_next   = ST_IDLE;
                hex_cnt_next = 2'd0;
            end
        endcase

        // Code point check and UTF-8 encoding
        if (em_cp && (cp > 21'h10FFFF || (cp >= 21'h00D800 && cp <= 21'h00DFFF)))
        begin
            fin = 1'b1; fin_kind = KIND_ERR; fin_err = ERR_INVALID;
        end
        else if (em_cp)
        begin
            emit = 1'b1;
            if (cp <= 21'h7F)
            begin
                em_bytes[0] = cp[7:0];
                em_last     = 2'd0;
            end
            else if (cp <= 21'h7FF)
            begin
                em_bytes[0] = {3'b110, cp[10:6]};
                em_bytes[1] = {2'b10, cp[5:0]};
                em_last     = 2'd1;
            end
            else if (cp <= 21'hFFFF)
            begin
                em_bytes[0] = {4'b1110, cp[15:12]};
                em_bytes[1] = {2'b10, cp[11:6]};
                em_bytes[2] = {2'b10, cp[5:0]};
                em_last     = 2'd2;
            end
            else
            begin
                em_bytes[0] = {5'b11110, cp[20:18]};
                em_bytes[1] = {2'b10, cp[17:12]};
                em_bytes[2] = {2'b10, cp[11:6]};
                em_bytes[3] = {2'b10, cp[5:0]};
                em_last     = 2'd3;
            end
        end
        else if (em_raw)
        begin
            emit        = 1'b1;
            em_bytes[0] = raw_byte;
            em_last     = 2'd0;
        end

        // Length limit on the whole character
        em_n      = {1'b0, em_last} + 3'd1;
        count_sum = count_reg + COUNT_WIDTH'(em_n);
        if (emit)
        begin
            if (count_sum > {1'b0, limit})
            begin
                fin = 1'b1; fin_kind = KIND_ERR; fin_err = ERR_LIMIT;
            end
            else
            begin
                push                = in_accept;
                push_entry.bytes    = em_bytes;
                push_entry.last_idx = em_last;
                push_entry.kind     = KIND_DATA;
                push_entry.err      = ERR_NONE;
                count_next          = count_sum;
                state_next          = ST_BODY;
            end
        end

        // Completion or error ends the string
        if (fin)
        begin
            push                = in_accept;
            push_entry          = '0;
            push_entry.kind     = fin_kind;
            push_entry.err      = (fin_kind == KIND_ERR) ? fin_err : ERR_NONE;
            state_next          = ST_IDLE;
            hex_cnt_next        = 2'd0;
        end
    end

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            hex_cnt_reg <= 2'd0;
            unit1_reg   <= 16'd0;
            unit2_reg   <= 16'd0;
            count_reg   <= '0;
        end
        else if (in_accept)
        begin
            state_reg   <= state_next;
            hex_cnt_reg <= hex_cnt_next;
            unit1_reg   <= unit1_next;
            unit2_reg   <= unit2_next;
            count_reg   <= count_next;
        end
    end

endmodule

// ===== src/jsu_queue.sv =====
`timescale 1ns / 1ps
// ============================================================================
// jsu_queue
// Short FIFO of result entries between the parser and the output stage.
// ============================================================================
module jsu_queue
    import jsu_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    input  logic   pop,
    output logic   full,
    output logic   head_valid,
    output entry_t head_entry
);

    entry_t                mem_reg [QDEPTH];
    logic [QPTR_WIDTH-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_WIDTH-1:0] cnt_reg, cnt_next;

    assign full       = (cnt_reg == QCNT_WIDTH'(QDEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_entry = mem_reg[rd_ptr_reg];

    // Occupancy
    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + QCNT_WIDTH'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - QCNT_WIDTH'(1);
        end
    end

    // Pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_WIDTH'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_WIDTH'(1);
            end
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== src/jsu_back.sv =====
`timescale 1ns / 1ps
// ============================================================================
// jsu_back
// Output stage: walks the head entry one result per beat into an output
// register and pops the entry as its final result is loaded.
// ============================================================================
module jsu_back
    import jsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  entry_t     head_entry,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output kind_t      out_kind,
    output err_t       out_err,
    output logic       out_last
);

    logic       valid_reg, valid_next;
    logic [1:0] idx_reg, idx_next;
    logic [7:0] byte_reg;
    kind_t      kind_reg;
    err_t       err_reg;
    logic       last_reg;
    logic       load;
    logic       at_last;

    assign load    = head_valid && (!valid_reg || out_ready);
    assign at_last = (idx_reg == head_entry.last_idx);
    assign pop     = load && at_last;

    // Beat index and output valid
    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg && !out_ready;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = at_last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= head_entry.bytes[idx_reg];
            kind_reg <= head_entry.kind;
            err_reg  <= head_entry.err;
            last_reg <= at_last;
        end
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign out_kind  = kind_reg;
    assign out_err   = err_reg;
    assign out_last  = last_reg;

endmodule

// ===== src/json_string_unescape_utf8_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// json_string_unescape_utf8_top
// JSON string unescaper with UTF-8 output.
// ============================================================================
// Usage:
//   Slave stream: one raw byte of JSON text per beat in s_axis_tdata; set
//   s_axis_tlast to mark end of text (the byte is then ignored). Each string
//   starts with its opening quote.
//   Master stream: one result per beat. tdata is the decoded byte, tuser
//   holds kind (data, string done, error) and the error code, tlast marks
//   the final result caused by one input byte.
//   Config channel: cfg_data sets the most decoded bytes allowed per string
//   (4096 after reset); write it only while the block is idle.
//   Throughput: one input byte per cycle. An input byte yields up to four
//   results, which wait in an eight-entry result queue; the output stage
//   drains one beat per cycle, so the input stalls when the queue fills,
//   as when the receiver holds off or multi-byte results drain slower.
//   A result is registered in the queue, then in the output register. When
//   the receiver stalls, the queue fills and s_axis_tready drops.
//   Reset clears the parser (awaiting opening quote), queue and output stage.
// ============================================================================
module json_string_unescape_utf8_top
    import jsu_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Configuration write
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [LIMIT_WIDTH-1:0] cfg_data,   // max_string_bytes
    // Input stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,   // [7:0] in_byte
    input  logic                   s_axis_tlast,   // input_end
    // Output stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [7:0]             m_axis_tdata,   // [7:0] out_byte
    output logic [4:0]             m_axis_tuser,   // [1:0] result_kind, [4:2] error_code
    output logic                   m_axis_tlast    // last_of_run
);

    logic [LIMIT_WIDTH-1:0] limit_reg;
    logic   in_accept;
    logic   q_push;
    entry_t q_push_entry;
    logic   q_pop;
    logic   q_full;
    logic   q_head_valid;
    entry_t q_head_entry;
    kind_t  out_kind;
    err_t   out_err;

    // Limit register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_valid)
        begin
            limit_reg <= cfg_data;
        end
    end

    // Input beat handshake
    assign s_axis_tready = !q_full;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    jsu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_accept  (in_accept),
        .in_byte    (s_axis_tdata),
        .in_end     (s_axis_tlast),
        .limit      (limit_reg),
        .push       (q_push),
        .push_entry (q_push_entry)
    );

    jsu_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_push_entry),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (q_head_valid),
        .head_entry (q_head_entry)
    );

    jsu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head_entry (q_head_entry),
        .pop        (q_pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_byte   (m_axis_tdata),
        .out_kind   (out_kind),
        .out_err    (out_err),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tuser = {out_err, out_kind};

    // Checks
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("result entry pushed into full queue");

    a_status_single: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_kind != KIND_DATA) |-> m_axis_tlast)
        else $error("completion or error result not last of its run");

    a_err_only_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_kind != KIND_ERR) |-> (out_err == ERR_NONE))
        else $error("error code set on non-error result");

    a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_head_valid)
        else $error("queue popped while empty");

endmodule
